// ----- sv/led_blink_word_decoder_defines.svh -----
// Assertion macros for the checker file of the LED word decoder.
`ifndef LED_BLINK_WORD_DECODER_DEFINES_SVH
`define LED_BLINK_WORD_DECODER_DEFINES_SVH

// Clocked check, suspended while reset is asserted.
`define LBWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LBWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/lbwd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbwd_pkg
// Types and constants of the blinking LED word decoder.
// ----------------------------------------------------------------------------
package lbwd_pkg;

  localparam int unsigned WORD_BITS  = 5;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned DARK_W     = 9;
  localparam int unsigned CNT_W      = 3;
  localparam logic [DARK_W-1:0] DARK_MAX = 9'd511;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RED_THR  = 2'd0,
    CFG_BLUE_THR = 2'd1,
    CFG_LIFETIME = 2'd2
  } lbwd_cfg_idx_t;

  localparam logic [LEVEL_W-1:0] RED_THR_RST  = 8'd100;
  localparam logic [LEVEL_W-1:0] BLUE_THR_RST = 8'd50;
  localparam logic [LEVEL_W-1:0] LIFETIME_RST = 8'd60;

  // request codes
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] blue_level;
  } lbwd_in_t;

  typedef struct packed {
    logic                 alive;
    logic                 receiving;
    logic                 word_ready;
    logic [WORD_BITS-1:0] last_word;
    logic                 id_valid;
    logic [1:0]           id_value;
    logic                 color_valid;
    logic [1:0]           color_value;
    logic                 cursor;
  } lbwd_out_t;

endpackage
`default_nettype wire

// ----- sv/led_blink_word_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// led_blink_word_decoder
// Per-frame bit decoder for one tracked blinking LED.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per video frame sample (req_type 0) or tracker
//           restart (req_type 1). Accepted when in_valid && !in_stall.
//   out_* : one transaction per input transaction, carrying the tracker
//           state after that item (alive, receiving, word_ready, last word,
//           id, color, cursor). Taken when out_valid && !out_stall.
//   cfg_* : write-only register port (red/blue threshold, lifetime); the user
//           writes it only while no transaction is in flight; not enforced.
// Path: an accepted item sits in the input register, then passes the update
//   logic into the result register.
// Throughput: one item per cycle while out_stall does not hold a full result
//   register; the tracker state update is a single compare/shift/count pass.
// Stall: when out_stall holds a full result register, the input register
//   keeps its item and in_stall rises while it is occupied; no transaction
//   is dropped or repeated.
// Reset: synchronous active-low; tracker is dead, id/color invalid, all
//   counters zero, thresholds back to 100/50/60, both pipe stages empty.
// ----------------------------------------------------------------------------
module led_blink_word_decoder
  import lbwd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lbwd_in_t           in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lbwd_out_t               out_data,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [LEVEL_W-1:0] cfg_data
);

  // configuration registers
  logic [LEVEL_W-1:0] red_thr_r, blue_thr_r, lifetime_r;

  // pipe registers
  logic      in_vld_r;
  lbwd_in_t  in_data_r;
  logic      out_vld_r;
  lbwd_out_t out_data_r;

  // tracker state
  logic                 alive_r,   alive_nxt;
  logic                 recv_r,    recv_nxt;
  logic [WORD_BITS-1:0] shift_r,   shift_nxt;
  logic [CNT_W-1:0]     cnt_r,     cnt_nxt;
  logic [WORD_BITS-1:0] held_r,    held_nxt;
  logic [DARK_W-1:0]    dark_r,    dark_nxt;
  logic                 id_ok_r,   id_ok_nxt;
  logic [1:0]           id_val_r,  id_val_nxt;
  logic                 col_ok_r,  col_ok_nxt;
  logic [1:0]           col_val_r, col_val_nxt;
  logic                 cursor_r,  cursor_nxt;
  logic                 ready_nxt;

  logic advance;      // result register free to take a new result
  logic step;         // input register item is processed this cycle

  assign advance   = !out_vld_r || !out_stall;
  assign step      = in_vld_r && advance;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_thr_r  <= RED_THR_RST;
      blue_thr_r <= BLUE_THR_RST;
      lifetime_r <= LIFETIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RED_THR:  red_thr_r  <= cfg_data;
        CFG_BLUE_THR: blue_thr_r <= cfg_data;
        CFG_LIFETIME: lifetime_r <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // tracker update, one pass per item
  // --------------------------------------------------------------------------
  always_comb begin
    logic                 bit_in;
    logic [WORD_BITS-1:0] sh;
    logic [CNT_W-1:0]     cn;
    logic [1:0]           wid;
    logic                 even;

    alive_nxt   = alive_r;
    recv_nxt    = recv_r;
    shift_nxt   = shift_r;
    cnt_nxt     = cnt_r;
    held_nxt    = held_r;
    dark_nxt    = dark_r;
    id_ok_nxt   = id_ok_r;
    id_val_nxt  = id_val_r;
    col_ok_nxt  = col_ok_r;
    col_val_nxt = col_val_r;
    cursor_nxt  = cursor_r;
    ready_nxt   = 1'b0;

    bit_in = in_data_r.red_level > red_thr_r;
    sh     = {shift_r[WORD_BITS-2:0], bit_in};
    cn     = cnt_r + CNT_W'(1);
    wid    = sh[4:3];
    even   = ~^sh;

    if (in_data_r.req_type == REQ_RESTART) begin
      alive_nxt = 1'b1;
    end else if (alive_r) begin
      cursor_nxt = in_data_r.blue_level > blue_thr_r;

      // run of dark frames, saturating
      if (!bit_in) begin
        if (dark_r != DARK_MAX) dark_nxt = dark_r + DARK_W'(1);
      end else begin
        dark_nxt = '0;
      end

      if (!recv_r) begin
        if (bit_in) recv_nxt = 1'b1;   // start bit
      end else begin
        shift_nxt = sh;
        cnt_nxt   = cn;
        if (cn >= CNT_W'(WORD_BITS)) begin
          recv_nxt  = 1'b0;
          held_nxt  = sh;
          shift_nxt = '0;
          cnt_nxt   = '0;
          ready_nxt = 1'b1;
          // even parity word: lock id first time, then set color on match
          if (even) begin
            if (!id_ok_r) begin
              id_ok_nxt  = 1'b1;
              id_val_nxt = wid;
            end
            if ((id_ok_r ? id_val_r : wid) == wid) begin
              col_ok_nxt  = 1'b1;
              col_val_nxt = sh[2:1];
            end
          end
        end
      end

      // lifetime exceeded: kill tracker, cursor keeps its new value
      if (dark_nxt > {1'b0, lifetime_r}) begin
        alive_nxt   = 1'b0;
        recv_nxt    = 1'b0;
        shift_nxt   = '0;
        cnt_nxt     = '0;
        held_nxt    = '0;
        dark_nxt    = '0;
        id_ok_nxt   = 1'b0;
        id_val_nxt  = '0;
        col_ok_nxt  = 1'b0;
        col_val_nxt = '0;
        ready_nxt   = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      alive_r   <= 1'b0;
      recv_r    <= 1'b0;
      shift_r   <= '0;
      cnt_r     <= '0;
      held_r    <= '0;
      dark_r    <= '0;
      id_ok_r   <= 1'b0;
      id_val_r  <= '0;
      col_ok_r  <= 1'b0;
      col_val_r <= '0;
      cursor_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) in_vld_r <= 1'b1;
      else if (step)             in_vld_r <= 1'b0;

      if (step)         out_vld_r <= 1'b1;
      else if (advance) out_vld_r <= 1'b0;

      if (step) begin
        alive_r   <= alive_nxt;
        recv_r    <= recv_nxt;
        shift_r   <= shift_nxt;
        cnt_r     <= cnt_nxt;
        held_r    <= held_nxt;
        dark_r    <= dark_nxt;
        id_ok_r   <= id_ok_nxt;
        id_val_r  <= id_val_nxt;
        col_ok_r  <= col_ok_nxt;
        col_val_r <= col_val_nxt;
        cursor_r  <= cursor_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
    if (step) begin
      out_data_r.alive       <= alive_nxt;
      out_data_r.receiving   <= recv_nxt;
      out_data_r.word_ready  <= ready_nxt;
      out_data_r.last_word   <= held_nxt;
      out_data_r.id_valid    <= id_ok_nxt;
      out_data_r.id_value    <= id_ok_nxt ? id_val_nxt : 2'd0;
      out_data_r.color_valid <= col_ok_nxt;
      out_data_r.color_value <= col_ok_nxt ? col_val_nxt : 2'd0;
      out_data_r.cursor      <= cursor_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lbwd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbwd_checker
// Port-level checks of the LED word decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_blink_word_decoder_defines.svh"

module lbwd_checker
  import lbwd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire lbwd_out_t out_data
);

  // a finished word always belongs to a live tracker that stopped shifting
  `LBWD_ASSERT(a_word_ctx, out_valid && out_data.word_ready |-> out_data.alive && !out_data.receiving, "word_ready without live idle tracker")

  // color is only set once an id is locked
  `LBWD_ASSERT(a_color_id, out_valid && out_data.color_valid |-> out_data.id_valid, "color valid without id")

  // invalid fields read as zero
  `LBWD_ASSERT(a_zero_inv, out_valid |-> (out_data.id_valid || out_data.id_value == 2'd0) && (out_data.color_valid || out_data.color_value == 2'd0), "invalid id or color not zero")

  // a stalled result holds
  `LBWD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind led_blink_word_decoder lbwd_checker u_lbwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
